// ----- sv/scc_pkg.sv -----
`timescale 1ns / 1ps
// scc_pkg: types, codes and the crc3 tables for the spi frame codec
// depends on nothing; imported by the interfaces, the codec and its checker
package scc_pkg;

  localparam int unsigned FrameW   = 24;
  localparam int unsigned AddrW    = 7;
  localparam int unsigned DataW    = 8;
  localparam int unsigned DevStW   = 5;
  localparam int unsigned CrcW     = 3;
  localparam int unsigned CrcSteps = 21;

  localparam logic [FrameW-1:0] CrcInMask  = 24'hFFFFF8;
  localparam logic [FrameW-1:0] CrcSeedBit = 24'h800000;
  localparam logic [FrameW-1:0] CrcPoly    = 24'hB00000;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CHECK = 2'd2
  } scc_mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_ADDR_ERR = 2'd2
  } scc_status_e;

  typedef logic [FrameW-1:0][CrcW-1:0] scc_crc_tab_t;

  // plain shift register division, evaluated at elaboration only
  function automatic logic [CrcW-1:0] crc3_raw(input logic [FrameW-1:0] din);
    logic [FrameW-1:0] d;
    d = din;
    for (int i = 0; i < CrcSteps; i++) begin
      if (d[FrameW-1]) begin
        d = d ^ CrcPoly;
      end
      d = {d[FrameW-2:0], 1'b0};
    end
    return d[FrameW-1 -: CrcW];
  endfunction

  // contribution of each frame bit to the crc
  function automatic scc_crc_tab_t crc3_table();
    scc_crc_tab_t tab;
    for (int i = 0; i < FrameW; i++) begin
      tab[i] = CrcInMask[i] ? crc3_raw(FrameW'(1) << i) : '0;
    end
    return tab;
  endfunction

  localparam scc_crc_tab_t      CrcTab  = crc3_table();
  localparam logic [CrcW-1:0]   CrcSeed = crc3_raw(CrcSeedBit);

  // crc3 as an xor of independent per-bit terms
  function automatic logic [CrcW-1:0] crc3_of(input logic [FrameW-1:0] frame);
    logic [CrcW-1:0] acc;
    acc = CrcSeed;
    for (int i = 0; i < FrameW; i++) begin
      if (frame[i]) begin
        acc = acc ^ CrcTab[i];
      end
    end
    return acc;
  endfunction

endpackage

// ----- sv/scc_stream_if.sv -----
`timescale 1ns / 1ps
// scc_in_if / scc_out_if: valid-ready channels of the spi frame codec
// depends on scc_pkg for field widths
interface scc_in_if;
  import scc_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [AddrW-1:0]    reg_addr;
  logic [DataW-1:0]    write_data;
  logic [FrameW-1:0]   rx_frame;

  modport source (output valid, mode, reg_addr, write_data, rx_frame, input ready);
  modport sink   (input valid, mode, reg_addr, write_data, rx_frame, output ready);
endinterface

interface scc_out_if;
  import scc_pkg::*;
  logic                valid;
  logic                ready;
  logic [FrameW-1:0]   frame_out;
  logic [1:0]          status;
  logic [DataW-1:0]    read_data;
  logic [DevStW-1:0]   device_status;

  modport source (output valid, frame_out, status, read_data, device_status, input ready);
  modport sink   (input valid, frame_out, status, read_data, device_status, output ready);
endinterface

// ----- sv/spi_frame_crc3_codec.sv -----
`timescale 1ns / 1ps
// spi_frame_crc3_codec: builds and checks 24-bit spi frames with a 3-bit crc
// results pass the input register, then the result register; one transfer per cycle sustained while out_o.ready is high
// the crc is an xor network between the input register and the result register
// reset clears both stage valid flags; payload registers are not reset
// depends on scc_pkg and scc_stream_if
module spi_frame_crc3_codec
  import scc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  scc_in_if.sink    in_i,
  scc_out_if.source out_o
);

  logic              s1_valid_q;
  logic [1:0]        mode_q;
  logic [AddrW-1:0]  addr_q;
  logic [DataW-1:0]  wdat_q;
  logic [FrameW-1:0] rx_q;

  logic              s2_valid_q;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [1:0]        status_q, status_d;
  logic [DataW-1:0]  rdata_q, rdata_d;
  logic [DevStW-1:0] devst_q, devst_d;

  logic adv2, adv1;
  logic [FrameW-1:0] build;

  assign adv2       = !s2_valid_q || out_o.ready;
  assign adv1       = !s1_valid_q || adv2;
  assign in_i.ready = adv1;

  always_comb begin
    frame_d  = '0;
    status_d = ST_OK;
    rdata_d  = '0;
    devst_d  = '0;
    build    = '0;
    unique case (mode_q)
      MODE_WRITE: begin
        build   = {1'b1, addr_q, wdat_q, 8'h00};
        frame_d = {build[FrameW-1:CrcW], crc3_of(build)};
      end
      MODE_READ: begin
        build   = {1'b0, addr_q, 16'h0000};
        frame_d = {build[FrameW-1:CrcW], crc3_of(build)};
      end
      MODE_CHECK: begin
        devst_d = rx_q[23:19];
        if (rx_q[CrcW-1:0] != crc3_of(rx_q)) begin
          status_d = ST_CRC_ERR;
        end else if (rx_q[18:12] != addr_q) begin
          status_d = ST_ADDR_ERR;
        end else begin
          rdata_d = rx_q[11:4];
        end
      end
      default: begin
        frame_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_q <= in_i.valid;
      end
      if (adv2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_i.valid) begin
      mode_q <= in_i.mode;
      addr_q <= in_i.reg_addr;
      wdat_q <= in_i.write_data;
      rx_q   <= in_i.rx_frame;
    end
    if (adv2 && s1_valid_q) begin
      frame_q  <= frame_d;
      status_q <= status_d;
      rdata_q  <= rdata_d;
      devst_q  <= devst_d;
    end
  end

  assign out_o.valid         = s2_valid_q;
  assign out_o.frame_out     = frame_q;
  assign out_o.status        = status_q;
  assign out_o.read_data     = rdata_q;
  assign out_o.device_status = devst_q;

endmodule

// ----- sv/scc_checker.sv -----
`timescale 1ns / 1ps
// scc_assert: port-level assertions for the spi frame codec, bound to spi_frame_crc3_codec
// depends on scc_pkg and spi_frame_crc3_codec
module scc_assert
  import scc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [FrameW-1:0] frame_out_i,
  input logic [1:0]        status_i,
  input logic [DataW-1:0]  read_data_i,
  input logic [DevStW-1:0] device_status_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a built frame carries no check results
  a_build_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_out_i != '0 |-> status_i == ST_OK && device_status_i == '0)
    else $error("built frame with check fields set");

  // failed check returns no data
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> read_data_i == '0 && frame_out_i == '0)
    else $error("data returned on failed check");

  // status never takes the unused code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i == ST_OK || status_i == ST_CRC_ERR || status_i == ST_ADDR_ERR)
    else $error("invalid status code");

endmodule

bind spi_frame_crc3_codec scc_assert u_scc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .frame_out_i     (out_o.frame_out),
  .status_i        (out_o.status),
  .read_data_i     (out_o.read_data),
  .device_status_i (out_o.device_status)
);
